FILE: rtl/core/lcsr_pkg.sv
package lcsr_pkg;

  localparam int MaxLines = 16;
  localparam int BlkW     = 32;
  localparam int CfgW     = 5;
  localparam int LinesW   = 5;
  localparam int CntW     = $clog2(MaxLines + 1);
  localparam int AgeW     = (MaxLines > 1) ? $clog2(MaxLines) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StCommit
  } state_e;

  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } cmd_t;

endpackage

FILE: rtl/core/lcsr_ctrl.sv
module lcsr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lcsr_pkg::cmd_t  cmd_o
);
  import lcsr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   ready;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = !ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    ready       = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        ready = 1'b1;
      end
      StLookup: begin
        cmd_o.lookup = 1'b1;
        state_d      = StCommit;
      end
      StCommit: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          ready        = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    // a new request may enter in the same cycle the previous one commits
    if (ready && in_valid_i) begin
      cmd_o.load = 1'b1;
      state_d    = StLookup;
    end
  end

endmodule

FILE: rtl/core/lcsr_datapath.sv
module lcsr_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lcsr_pkg::cmd_t               cmd_i,
  input  logic                         cfg_we_i,
  input  logic [lcsr_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                         func_i,
  input  logic [lcsr_pkg::BlkW-1:0]    block_id_i,
  output logic                         hit_o,
  output logic                         evicted_valid_o,
  output logic [lcsr_pkg::BlkW-1:0]    evicted_block_o,
  output logic                         evicted_dirty_o,
  output logic [lcsr_pkg::LinesW-1:0]  lines_used_o
);
  import lcsr_pkg::*;

  // line store
  logic [BlkW-1:0]     blk_q   [MaxLines];
  logic [BlkW-1:0]     blk_d   [MaxLines];
  logic [MaxLines-1:0] valid_q, valid_d;
  logic [MaxLines-1:0] dirty_q, dirty_d;
  logic [AgeW-1:0]     age_q   [MaxLines];
  logic [AgeW-1:0]     age_d   [MaxLines];
  logic [CntW-1:0]     occ_q, occ_d;
  logic [CfgW-1:0]     active_q;

  // request and lookup results
  logic                req_func_q;
  logic [BlkW-1:0]     req_blk_q;
  logic [MaxLines-1:0] hit_vec_q, hit_vec_d;
  logic [MaxLines-1:0] lru_vec_q, lru_vec_d;
  logic [AgeW-1:0]     hit_age_q, hit_age_d;
  logic                evict_q, evict_d;
  logic [BlkW-1:0]     ev_blk_q, ev_blk_d;
  logic                ev_dirty_q, ev_dirty_d;

  // result register
  logic                hit_q;
  logic                ev_valid_oq;
  logic [BlkW-1:0]     ev_blk_oq;
  logic                ev_dirty_oq;
  logic [LinesW-1:0]   lines_q;

  logic [CntW-1:0]     limit;
  logic [CntW-1:0]     active_ext;
  logic [AgeW-1:0]     lru_age;
  logic                hit;
  logic [MaxLines-1:0] clr_vec;
  logic [MaxLines-1:0] free_vec;
  logic [MaxLines-1:0] slot_vec;

  assign active_ext = CntW'(active_q);
  assign lru_age    = AgeW'(occ_q - CntW'(1));

  always_comb begin
    if (active_q == '0) begin
      limit = CntW'(1);
    end else if (active_ext > CntW'(MaxLines)) begin
      limit = CntW'(MaxLines);
    end else begin
      limit = active_ext;
    end
  end

  // lookup: tag compare and LRU pick over all lines
  always_comb begin
    hit_age_d  = '0;
    ev_blk_d   = '0;
    ev_dirty_d = 1'b0;
    for (int i = 0; i < MaxLines; i++) begin
      hit_vec_d[i] = valid_q[i] && (blk_q[i] == req_blk_q);
      lru_vec_d[i] = valid_q[i] && (age_q[i] == lru_age);
    end
    evict_d = (hit_vec_d == '0) && (occ_q >= limit) && (occ_q != '0);
    for (int i = 0; i < MaxLines; i++) begin
      hit_age_d = hit_age_d | (age_q[i] & {AgeW{hit_vec_d[i]}});
      ev_blk_d  = ev_blk_d | (blk_q[i] & {BlkW{lru_vec_d[i] && evict_d}});
      ev_dirty_d = ev_dirty_d | (dirty_q[i] && lru_vec_d[i] && evict_d);
    end
  end

  // commit: recency, dirty and fill update
  assign hit      = |hit_vec_q;
  assign clr_vec  = evict_q ? lru_vec_q : '0;
  assign free_vec = ~valid_q | clr_vec;
  assign slot_vec = free_vec & (~free_vec + MaxLines'(1));

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    occ_d   = occ_q;
    for (int i = 0; i < MaxLines; i++) begin
      blk_d[i] = blk_q[i];
      age_d[i] = age_q[i];
    end
    if (hit) begin
      for (int i = 0; i < MaxLines; i++) begin
        if (hit_vec_q[i]) begin
          age_d[i]   = '0;
          dirty_d[i] = dirty_q[i] | req_func_q;
        end else if (valid_q[i] && (age_q[i] < hit_age_q)) begin
          age_d[i] = age_q[i] + AgeW'(1);
        end
      end
    end else begin
      for (int i = 0; i < MaxLines; i++) begin
        if (slot_vec[i]) begin
          valid_d[i] = 1'b1;
          dirty_d[i] = 1'b0;
          age_d[i]   = '0;
          blk_d[i]   = req_blk_q;
        end else if (clr_vec[i]) begin
          valid_d[i] = 1'b0;
          dirty_d[i] = 1'b0;
          age_d[i]   = '0;
        end else if (valid_q[i]) begin
          age_d[i] = age_q[i] + AgeW'(1);
        end
      end
      occ_d = occ_q - CntW'(evict_q) + CntW'(|free_vec);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      dirty_q  <= '0;
      occ_q    <= '0;
      active_q <= CfgW'(16);
      for (int i = 0; i < MaxLines; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        valid_q <= valid_d;
        dirty_q <= dirty_d;
        occ_q   <= occ_d;
        for (int i = 0; i < MaxLines; i++) begin
          age_q[i] <= age_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_func_q <= func_i;
      req_blk_q  <= block_id_i;
    end
    if (cmd_i.lookup) begin
      hit_vec_q  <= hit_vec_d;
      lru_vec_q  <= lru_vec_d;
      hit_age_q  <= hit_age_d;
      evict_q    <= evict_d;
      ev_blk_q   <= ev_blk_d;
      ev_dirty_q <= ev_dirty_d;
    end
    if (cmd_i.commit) begin
      for (int i = 0; i < MaxLines; i++) begin
        blk_q[i] <= blk_d[i];
      end
      hit_q       <= hit;
      ev_valid_oq <= evict_q;
      ev_blk_oq   <= ev_blk_q;
      ev_dirty_oq <= ev_dirty_q;
      lines_q     <= LinesW'(occ_d);
    end
  end

  assign hit_o           = hit_q;
  assign evicted_valid_o = ev_valid_oq;
  assign evicted_block_o = ev_blk_oq;
  assign evicted_dirty_o = ev_dirty_oq;
  assign lines_used_o    = lines_q;

endmodule

FILE: rtl/core/lru_cache_set_replacement.sv
// LRU replacement for one fully associative set of up to 16 lines. Each request is a read or
// write of a 32-bit block id; every request gives exactly one result with hit, eviction
// (block id and dirty mark, zero when none) and lines in use afterwards. A request passes a
// lookup state, for the tag compare across all lines and the pick of the least recently used
// line, and a commit state, to update recency ranks, dirty marks and the fill. The next
// request is taken in the cycle the previous one commits, so only one is in flight. A result
// waiting on the output stalls the commit, not the lookup. The line count register is written
// with cfg_we_i; 0 acts as 1 and values above 16 act as 16. Lowering it below the current fill
// evicts one line per later miss. Write it only while the block is idle.
module lru_cache_set_replacement (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lcsr_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [lcsr_pkg::BlkW-1:0]    block_id_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic                         evicted_valid_o,
  output logic [lcsr_pkg::BlkW-1:0]    evicted_block_o,
  output logic                         evicted_dirty_o,
  output logic [lcsr_pkg::LinesW-1:0]  lines_used_o
);
  import lcsr_pkg::*;

  cmd_t cmd;

  lcsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lcsr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .block_id_i      (block_id_i),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_block_o (evicted_block_o),
    .evicted_dirty_o (evicted_dirty_o),
    .lines_used_o    (lines_used_o)
  );

endmodule

FILE: rtl/core/lcsr_checker.sv
module lcsr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         hit_o,
  input logic                         evicted_valid_o,
  input logic [lcsr_pkg::BlkW-1:0]    evicted_block_o,
  input logic                         evicted_dirty_o,
  input logic [lcsr_pkg::LinesW-1:0]  lines_used_o
);
  import lcsr_pkg::*;

  // held hit, lines in use and evicted block do not change while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) && $stable(lines_used_o)
      && $stable(evicted_block_o))
    else $error("stalled result changed");

  // each request passes the lookup state before the next one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken during lookup");

  // no eviction on a hit, and no eviction data without an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hit_o || !evicted_valid_o) |->
      !evicted_valid_o && evicted_block_o == '0 && !evicted_dirty_o)
    else $error("eviction fields inconsistent");

  // fill never exceeds MaxLines and a result never reports an empty set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lines_used_o <= LinesW'(MaxLines) && lines_used_o != '0)
    else $error("lines in use out of range");

endmodule

bind lru_cache_set_replacement lcsr_checker u_lcsr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .hit_o           (hit_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_block_o (evicted_block_o),
  .evicted_dirty_o (evicted_dirty_o),
  .lines_used_o    (lines_used_o)
);

FILE: dv/lru_cache_set_replacement_tb.sv
module lru_cache_set_replacement_tb;
  import lcsr_pkg::*;

  localparam logic AccRead       = 1'b0;
  localparam logic AccWrite      = 1'b1;
  localparam int   WatchdogLimit = 2000;

  typedef struct packed {
    logic              hit;
    logic              ev_valid;
    logic [BlkW-1:0]   ev_block;
    logic              ev_dirty;
    logic [LinesW-1:0] used;
  } access_outcome_t;

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CfgW-1:0]   cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              func      = 1'b0;
  logic [BlkW-1:0]   block_id  = '0;
  logic              out_stall = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic              hit_o;
  logic              evicted_valid_o;
  logic [BlkW-1:0]   evicted_block_o;
  logic              evicted_dirty_o;
  logic [LinesW-1:0] lines_used_o;

  // predictor copy of the set
  logic [BlkW-1:0] line_blk  [MaxLines];
  logic            line_vld  [MaxLines];
  logic            line_drt  [MaxLines];
  logic [AgeW-1:0] line_rank [MaxLines];
  logic [CntW-1:0] fill;
  logic [CfgW-1:0] line_count;

  access_outcome_t awaited_outcomes[$];
  access_outcome_t want;
  int              mismatch_count = 0;
  int              quiet_cycles   = 0;
  bit              idle_on        = 1'b1;

  lru_cache_set_replacement DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .func_i          (func),
    .block_id_i      (block_id),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_block_o (evicted_block_o),
    .evicted_dirty_o (evicted_dirty_o),
    .lines_used_o    (lines_used_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void predict_lru_access(input logic fn, input logic [BlkW-1:0] blk);
    int              hit_idx;
    int              lru;
    int              slot;
    int              cap;
    access_outcome_t r;
    hit_idx = -1;
    lru     = -1;
    slot    = -1;
    r       = '0;
    cap = (line_count == 0) ? 1 : (line_count > MaxLines) ? MaxLines : int'(line_count);
    for (int i = 0; i < MaxLines; i++)
      if (hit_idx < 0 && line_vld[i] && line_blk[i] == blk) hit_idx = i;
    if (hit_idx >= 0) begin
      for (int i = 0; i < MaxLines; i++)
        if (line_vld[i] && line_rank[i] < line_rank[hit_idx]) line_rank[i]++;
      line_rank[hit_idx] = '0;
      if (fn == AccWrite) line_drt[hit_idx] = 1'b1;
      r.hit = 1'b1;
    end else begin
      // evict the oldest line first, then fill the lowest free slot
      if (fill >= cap) begin
        for (int i = 0; i < MaxLines; i++)
          if (line_vld[i] && (lru < 0 || line_rank[i] > line_rank[lru])) lru = i;
        if (lru >= 0) begin
          r.ev_valid     = 1'b1;
          r.ev_block     = line_blk[lru];
          r.ev_dirty     = line_drt[lru];
          line_vld[lru]  = 1'b0;
          line_drt[lru]  = 1'b0;
          line_rank[lru] = '0;
          fill--;
        end
      end
      for (int i = 0; i < MaxLines; i++)
        if (line_vld[i]) line_rank[i]++;
      for (int i = 0; i < MaxLines; i++)
        if (slot < 0 && !line_vld[i]) slot = i;
      if (slot >= 0) begin
        line_vld[slot]  = 1'b1;
        line_drt[slot]  = 1'b0;
        line_blk[slot]  = blk;
        line_rank[slot] = '0;
        fill++;
      end
    end
    r.used = fill[LinesW-1:0];
    awaited_outcomes.push_back(r);
  endfunction

  task automatic check_field(input string name, input logic [BlkW-1:0] exp_v,
                             input logic [BlkW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        check_field("hit", BlkW'(want.hit), BlkW'(hit_o));
        check_field("evicted_valid", BlkW'(want.ev_valid), BlkW'(evicted_valid_o));
        check_field("evicted_block", want.ev_block, evicted_block_o);
        check_field("evicted_dirty", BlkW'(want.ev_dirty), BlkW'(evicted_dirty_o));
        check_field("lines_used", BlkW'(want.used), BlkW'(lines_used_o));
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall <= idle_on && ($urandom_range(99) < 30);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("lru_cache_set_replacement_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_access(input logic fn, input logic [BlkW-1:0] blk);
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func     <= fn;
    block_id <= blk;
    do @(posedge clk_i); while (in_stall_o);
    predict_lru_access(fn, blk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_line_count(input logic [CfgW-1:0] v);
    wait_drained();
    repeat (3) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    line_count  = v;
  endtask

  task automatic run_access_phase(input logic [CfgW-1:0] count, input int n_req,
                                  input bit hold_once);
    logic [BlkW-1:0] pool[$];
    logic [BlkW-1:0] blk;
    int              pool_len;
    set_line_count(count);
    pool_len = $urandom_range(24, 2);
    for (int i = 0; i < pool_len; i++)
      if (i > 0 && $urandom_range(3) == 0) pool.push_back(pool[i-1] ^ (32'h1 << $urandom_range(31)));
      else pool.push_back($urandom);
    for (int k = 0; k < n_req; k++) begin
      if (hold_once && k == n_req / 2) wait_drained();
      if ($urandom_range(99) < 85) blk = pool[$urandom_range(pool_len - 1)];
      else blk = $urandom;
      send_access($urandom_range(1) ? AccWrite : AccRead, blk);
    end
  endtask

  // zero acts as one line; one line behaves the same
  task automatic test_single_line();
    set_line_count(5'd0);
    send_access(AccRead,  32'h0000_00A5);
    send_access(AccWrite, 32'h0000_00A5);
    send_access(AccRead,  32'h0000_00A4);
    send_access(AccWrite, 32'hC000_0003);
    set_line_count(5'd1);
    send_access(AccRead,  32'hC000_0003);
    send_access(AccRead,  32'h0000_0000);
  endtask

  task automatic test_hit_and_evict();
    set_line_count(5'd4);
    send_access(AccWrite, 32'hFFFF_FFFF);
    send_access(AccRead,  32'h0000_0001);
    send_access(AccRead,  32'h8000_0000);
    send_access(AccWrite, 32'h0000_0000);
    send_access(AccRead,  32'hFFFF_FFFF);
    send_access(AccRead,  32'h7FFF_FFFF);
    send_access(AccWrite, 32'h8000_0000);
    send_access(AccRead,  32'h0000_0001);
    send_access(AccRead,  32'h0000_0000);
    send_access(AccWrite, 32'hFFFF_FFFE);
  endtask

  task automatic test_growth();
    run_access_phase(5'd2, 90, 1'b0);
    run_access_phase(5'd5, 90, 1'b0);
    run_access_phase(5'($urandom_range(12, 6)), 100, 1'b0);
    run_access_phase(5'd16, 100, 1'b0);
    idle_on = 1'b0;
    run_access_phase(5'd31, 150, 1'b0);
    idle_on = 1'b1;
    run_access_phase(5'd17, 100, 1'b0);
  endtask

  // lines stay in place; every miss evicts one
  task automatic test_shrink_below_fill();
    set_line_count(5'd3);
    send_access(AccWrite, 32'h5A5A_0000);
    send_access(AccRead,  32'h5A5A_0001);
    send_access(AccWrite, 32'h5A5A_0000);
    send_access(AccRead,  32'h5A5A_0002);
    send_access(AccRead,  32'h5A5A_0001);
  endtask

  task automatic test_random_mixed();
    run_access_phase(5'd0, 100, 1'b0);
    run_access_phase(5'd31, 100, 1'b1);
    repeat (5) run_access_phase(5'($urandom_range(31)), 110, 1'b0);
  endtask

  initial begin
    foreach (line_vld[i]) begin
      line_blk[i]  = '0;
      line_vld[i]  = 1'b0;
      line_drt[i]  = 1'b0;
      line_rank[i] = '0;
    end
    fill       = '0;
    line_count = 5'd16;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_line();
    test_hit_and_evict();
    test_growth();
    test_shrink_below_fill();
    test_random_mixed();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("lru_cache_set_replacement_tb: clean");
    end else begin
      $display("lru_cache_set_replacement_tb: errors");
    end
    $finish;
  end

endmodule
